// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared definitions for the sorted timer queue
// Command codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEFAULT_TIMER_SLOTS = 16;
    localparam int MAX_RESULTS         = 16;
    localparam int COUNT_W             = 5;
    localparam int MODE_W              = 3;
    localparam int ID_W                = 4;
    localparam int TIME_W              = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_START    = 3'd1,
        MODE_STOP     = 3'd2,
        MODE_CONTINUE = 3'd3,
        MODE_QUERY    = 3'd4
    } mode_t;

endpackage

// ===== hdl/stq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// stq_slot_ram: per-slot expiry and arming rank store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stq_slot_ram #(
    parameter int DEPTH = stq_pkg::DEFAULT_TIMER_SLOTS,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer slots released in expiry order on a seconds tick
// Expiry and arming rank live in a slot RAM; each tick scans it for the
// earliest due slot, reports it and closes the rank gap with a second sweep.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser         | tlast
//  s_      | in  | mode[3], timer_id[4], delay_seconds[32]   | -             | -
//  m_      | out | expired_id[4], is_queued, seconds_left[32]| expired_valid | last_result
//
//  Start/stop with the slot queued: one RAM lookup, then a rank sweep.
//  Continue, query, other: one RAM lookup.
//  Tick: per reported slot two RAM sweeps; plus one
//  scan when fewer than sixteen are due. Sweeps read one RAM entry per cycle.
//  Reset empties the queue and zeroes the clock at once; no clearing pass.
//  A stalled result holds the machine only when the next result is ready.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
    parameter int TIMER_SLOTS = stq_pkg::DEFAULT_TIMER_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[2:0], timer_id[6:3], delay_seconds[38:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // expired_id[3:0], is_queued[4], seconds_left[36:5]
    output logic        m_tuser,   // expired_valid
    output logic        m_tlast    // last_result
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int TW = stq_pkg::TIME_W;
    localparam int DW = TW + SW;
    localparam logic [SW:0] SLOTS_P = (SW+1)'(TIMER_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_RDID, S_LOOK, S_SCAN, S_PUSH, S_DEC, S_ENQ, S_FINISH
    } state_t;

    state_t                      state_reg;
    stq_pkg::mode_t              cmd_reg;
    logic [stq_pkg::ID_W-1:0]    id_reg;
    logic [TW-1:0]               delay_reg;
    logic [TW-1:0]               now_reg;
    logic [CW-1:0]               arm_cnt_reg;
    logic [TIMER_SLOTS-1:0]      queued_reg;
    logic [TIMER_SLOTS-1:0]      stopped_reg;
    logic [SW:0]                 ptr_reg;
    logic                        rd_vld_reg;
    logic [SW-1:0]               rd_addr_q_reg;
    logic                        best_valid_reg;
    logic [SW-1:0]               best_id_reg;
    logic [TW-1:0]               best_exp_reg;
    logic [SW-1:0]               best_rank_reg;
    logic [SW-1:0]               rm_rank_reg;
    logic                        pend_valid_reg;
    logic [SW-1:0]               pend_id_reg;
    logic [stq_pkg::COUNT_W-1:0] count_reg;
    logic                        res_q_reg;
    logic [TW-1:0]               res_left_reg;
    logic                        m_valid_reg;
    logic                        out_ev_reg;
    logic [stq_pkg::ID_W-1:0]    out_id_reg;
    logic                        out_q_reg;
    logic [TW-1:0]               out_left_reg;
    logic                        out_last_reg;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [TW-1:0] rd_exp;
    logic [SW-1:0] rd_rank;
    logic          id_ok;
    logic [SW-1:0] id_idx;
    logic          sweep_more;
    logic          hit_queued;
    logic          better;
    logic          dec_wr;
    logic          out_free;
    logic          out_load;

    assign id_ok      = (32'(id_reg) < 32'(TIMER_SLOTS));
    assign id_idx     = SW'(id_reg);
    assign rd_exp     = rd_data[DW-1:SW];
    assign rd_rank    = rd_data[SW-1:0];
    assign sweep_more = (ptr_reg < SLOTS_P);
    assign hit_queued = rd_vld_reg && queued_reg[rd_addr_q_reg];
    assign better     = !best_valid_reg || (rd_exp < best_exp_reg) ||
                        ((rd_exp == best_exp_reg) && (rd_rank < best_rank_reg));
    assign dec_wr     = (state_reg == S_DEC) && hit_queued && (rd_rank > rm_rank_reg);
    assign out_free   = !m_valid_reg || m_tready;
    assign out_load   = out_free && (((state_reg == S_PUSH) && pend_valid_reg) ||
                                     (state_reg == S_FINISH));

    always_comb begin
        rd_en   = (state_reg == S_RDID) ||
                  (((state_reg == S_SCAN) || (state_reg == S_DEC)) && sweep_more);
        rd_addr = (state_reg == S_RDID) ? id_idx : ptr_reg[SW-1:0];
        wr_en   = dec_wr || (state_reg == S_ENQ);
        if (state_reg == S_ENQ) begin
            wr_addr = id_idx;
            wr_data = {now_reg + delay_reg, arm_cnt_reg[SW-1:0]};
        end else begin
            wr_addr = rd_addr_q_reg;
            wr_data = {rd_exp, rd_rank - SW'(1)};
        end
    end

    stq_slot_ram #(
        .DEPTH (TIMER_SLOTS),
        .AW    (SW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            arm_cnt_reg    <= '0;
            queued_reg     <= '0;
            stopped_reg    <= '0;
            m_valid_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg    <= ((state_reg == S_SCAN) || (state_reg == S_DEC)) && sweep_more;
            rd_addr_q_reg <= ptr_reg[SW-1:0];
            if (((state_reg == S_SCAN) || (state_reg == S_DEC)) && sweep_more) begin
                ptr_reg <= ptr_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg        <= stq_pkg::mode_t'(s_tdata[2:0]);
                        id_reg         <= s_tdata[6:3];
                        delay_reg      <= s_tdata[38:7];
                        res_q_reg      <= 1'b0;
                        res_left_reg   <= '0;
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        if (stq_pkg::mode_t'(s_tdata[2:0]) == stq_pkg::MODE_TICK) begin
                            now_reg        <= now_reg + 1'b1;
                            ptr_reg        <= '0;
                            best_valid_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end else begin
                            state_reg <= S_RDID;
                        end
                    end
                end
                S_RDID: state_reg <= S_LOOK;
                S_LOOK: begin
                    state_reg <= S_FINISH;
                    if (id_ok) begin
                        priority case (cmd_reg)
                            stq_pkg::MODE_QUERY: begin
                                res_q_reg <= queued_reg[id_idx];
                                if (queued_reg[id_idx] && (rd_exp > now_reg)) begin
                                    res_left_reg <= rd_exp - now_reg;
                                end
                            end
                            stq_pkg::MODE_START, stq_pkg::MODE_STOP: begin
                                if (cmd_reg == stq_pkg::MODE_STOP) begin
                                    stopped_reg[id_idx] <= 1'b1;
                                end
                                if (queued_reg[id_idx]) begin
                                    queued_reg[id_idx] <= 1'b0;
                                    arm_cnt_reg        <= arm_cnt_reg - 1'b1;
                                    rm_rank_reg        <= rd_rank;
                                    ptr_reg            <= '0;
                                    state_reg          <= S_DEC;
                                end else if (cmd_reg == stq_pkg::MODE_START) begin
                                    state_reg <= S_ENQ;
                                end
                            end
                            stq_pkg::MODE_CONTINUE: begin
                                if (!queued_reg[id_idx] && !stopped_reg[id_idx]) begin
                                    state_reg <= S_ENQ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit_queued && better) begin
                        best_valid_reg <= 1'b1;
                        best_id_reg    <= rd_addr_q_reg;
                        best_exp_reg   <= rd_exp;
                        best_rank_reg  <= rd_rank;
                    end
                    if (!sweep_more && !rd_vld_reg) begin
                        if (best_valid_reg && (best_exp_reg <= now_reg)) begin
                            state_reg <= S_PUSH;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_PUSH: begin
                    // previous due slot goes out before this one is taken
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_valid_reg  <= 1'b1;
                            out_ev_reg   <= 1'b1;
                            out_id_reg   <= stq_pkg::ID_W'(pend_id_reg);
                            out_q_reg    <= 1'b0;
                            out_left_reg <= '0;
                            out_last_reg <= 1'b0;
                        end
                        pend_valid_reg          <= 1'b1;
                        pend_id_reg             <= best_id_reg;
                        queued_reg[best_id_reg] <= 1'b0;
                        arm_cnt_reg             <= arm_cnt_reg - 1'b1;
                        count_reg               <= count_reg + 1'b1;
                        rm_rank_reg             <= best_rank_reg;
                        ptr_reg                 <= '0;
                        state_reg               <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (!sweep_more && !rd_vld_reg) begin
                        if (cmd_reg == stq_pkg::MODE_TICK) begin
                            if (count_reg == stq_pkg::COUNT_W'(stq_pkg::MAX_RESULTS)) begin
                                state_reg <= S_FINISH;
                            end else begin
                                ptr_reg        <= '0;
                                best_valid_reg <= 1'b0;
                                state_reg      <= S_SCAN;
                            end
                        end else if (cmd_reg == stq_pkg::MODE_START) begin
                            state_reg <= S_ENQ;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_ENQ: begin
                    queued_reg[id_idx]  <= 1'b1;
                    stopped_reg[id_idx] <= 1'b0;
                    arm_cnt_reg         <= arm_cnt_reg + 1'b1;
                    state_reg           <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        out_ev_reg   <= pend_valid_reg;
                        out_id_reg   <= pend_valid_reg ? stq_pkg::ID_W'(pend_id_reg) : '0;
                        out_q_reg    <= res_q_reg;
                        out_left_reg <= res_left_reg;
                        out_last_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_left_reg, out_q_reg, out_id_reg};
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/sv/tb_sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue: self-checking bench for the sorted timer queue
// Directed table then random command mix; every result is checked against an
// in-bench timer model, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;

    typedef struct packed {
        logic        valid;
        logic [3:0]  id;
        logic        queued;
        logic [31:0] left;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [2:0]  mode;
        logic [3:0]  id;
        logic [31:0] delay;
        bit          typed;     // expected result given in the row
        logic        q;
        logic [31:0] left;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sorted_timer_queue u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // timer model state
    logic [31:0] now_s;
    logic [31:0] expiry [16];
    logic [31:0] rank [16];
    bit          queued [16];
    bit          stopped [16];
    logic [31:0] n_armed;

    timer_result_t expected_q[$];
    int errors = 0;
    bit hold_off = 0;

    function automatic void drop_slot(int s);
        if (!queued[s]) return;
        queued[s] = 0;
        for (int k = 0; k < 16; k++)
            if (queued[k] && rank[k] > rank[s]) rank[k]--;
        n_armed--;
    endfunction

    function automatic void arm_slot(int s, logic [31:0] d);
        expiry[s] = now_s + d;
        rank[s] = n_armed;
        n_armed++;
        queued[s] = 1;
    endfunction

    // works out the results of one request and queues them
    function automatic void predict_timer(logic [2:0] mode, logic [3:0] id,
                                          logic [31:0] d);
        timer_result_t r;
        int cnt;
        int best;
        cnt = 0;
        r = '0;
        if (mode == stq_pkg::MODE_TICK) begin
            now_s++;
            while (cnt < stq_pkg::MAX_RESULTS) begin
                best = -1;
                for (int k = 0; k < 16; k++)
                    if (queued[k] && (best < 0 || expiry[k] < expiry[best] ||
                        (expiry[k] == expiry[best] && rank[k] < rank[best])))
                        best = k;
                if (best < 0 || expiry[best] > now_s) break;
                drop_slot(best);
                r = '0;
                r.valid = 1;
                r.id = best[3:0];
                expected_q.push_back(r);
                cnt++;
            end
            if (cnt == 0) begin
                r = '0;
                r.last = 1;
                expected_q.push_back(r);
            end else begin
                expected_q[$].last = 1;
            end
            return;
        end
        if (mode == stq_pkg::MODE_QUERY) begin
            if (queued[id]) begin
                r.queued = 1;
                if (expiry[id] > now_s) r.left = expiry[id] - now_s;
            end
        end else if (mode == stq_pkg::MODE_START) begin
            drop_slot(id);
            arm_slot(id, d);
            stopped[id] = 0;
        end else if (mode == stq_pkg::MODE_STOP) begin
            stopped[id] = 1;
            drop_slot(id);
        end else if (mode == stq_pkg::MODE_CONTINUE) begin
            if (!queued[id] && !stopped[id]) arm_slot(id, d);
        end
        r.last = 1;
        expected_q.push_back(r);
    endfunction

    // one request at the falling edge, held until accepted
    task automatic send_request(logic [2:0] mode, logic [3:0] id, logic [31:0] d);
        s_tdata <= {1'b0, d, id, mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_timer(mode, id, d);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    // receiver stall pattern plus one long hold-off
    initial begin
        int phase;
        phase = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_off) m_tready <= 1'b0;
            else if ((phase / 64) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid = m_tuser;
            got.id = m_tdata[3:0];
            got.queued = m_tdata[4];
            got.left = m_tdata[36:5];
            got.last = m_tlast;
            if (expected_q.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.valid !== exp_r.valid) begin
                    $error("expired_valid exp %0d got %0d", exp_r.valid, got.valid);
                    errors++;
                end
                if (got.id !== exp_r.id) begin
                    $error("expired_id exp %0d got %0d", exp_r.id, got.id);
                    errors++;
                end
                if (got.queued !== exp_r.queued) begin
                    $error("is_queued exp %0d got %0d", exp_r.queued, got.queued);
                    errors++;
                end
                if (got.left !== exp_r.left) begin
                    $error("seconds_left exp %0d got %0d", exp_r.left, got.left);
                    errors++;
                end
                if (got.last !== exp_r.last) begin
                    $error("last_result exp %0d got %0d", exp_r.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("tb_sorted_timer_queue: done, errors");
        $finish;
    end

    stim_row_t rows[$];

    function automatic void add_row(logic [2:0] m, logic [3:0] id, logic [31:0] d,
                                    bit typed = 0, logic q = 0, logic [31:0] l = 0);
        stim_row_t r;
        r.mode = m; r.id = id; r.delay = d; r.typed = typed; r.q = q; r.left = l;
        rows.push_back(r);
    endfunction

    initial begin
        int burst;
        int id_lo;
        logic [2:0] m;
        logic [31:0] d;
        now_s = 0;
        n_armed = 0;
        for (int k = 0; k < 16; k++) begin
            queued[k] = 0; stopped[k] = 0; expiry[k] = 0; rank[k] = 0;
        end

        // directed table: query after reset, extremes, ties, stop/continue
        add_row(stq_pkg::MODE_QUERY, 4'd15, 32'd0, 1, 1'b0, 32'd0);
        add_row(stq_pkg::MODE_TICK, 4'd0, 32'd0);
        // expiry wraps round to zero, so the slot is already due
        add_row(stq_pkg::MODE_START, 4'd15, 32'hFFFF_FFFF);
        add_row(stq_pkg::MODE_QUERY, 4'd15, 32'd0, 1, 1'b1, 32'd0);
        add_row(stq_pkg::MODE_START, 4'd3, 32'd2);
        add_row(stq_pkg::MODE_START, 4'd1, 32'd2);
        add_row(stq_pkg::MODE_START, 4'd0, 32'd0);
        add_row(stq_pkg::MODE_QUERY, 4'd0, 32'd0, 1, 1'b1, 32'd0);
        add_row(stq_pkg::MODE_TICK, 4'd0, 32'd0);
        add_row(stq_pkg::MODE_TICK, 4'd0, 32'd0);
        add_row(stq_pkg::MODE_STOP, 4'd15, 32'd0);
        add_row(stq_pkg::MODE_CONTINUE, 4'd15, 32'd1);
        add_row(stq_pkg::MODE_QUERY, 4'd15, 32'd0, 1, 1'b0, 32'd0);
        add_row(stq_pkg::MODE_START, 4'd15, 32'd1);
        add_row(stq_pkg::MODE_STOP, 4'd8, 32'd0);
        add_row(stq_pkg::MODE_CONTINUE, 4'd7, 32'd1);
        add_row(stq_pkg::MODE_CONTINUE, 4'd7, 32'd9);
        add_row(3'd5, 4'd2, 32'h5555_AAAA);
        add_row(3'd6, 4'd9, 32'hAAAA_5555);
        add_row(3'd7, 4'd15, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) add_row(stq_pkg::MODE_START, 4'(k + 9), 32'd1);
        add_row(stq_pkg::MODE_TICK, 4'd0, 32'd0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            send_request(rows[i].mode, rows[i].id, rows[i].delay);
            // typed rows: the table value replaces the model's guess
            if (rows[i].typed) begin
                expected_q[$].queued = rows[i].q;
                expected_q[$].left = rows[i].left;
            end
        end

        // all sixteen slots due on one tick
        drain_wait();
        for (int k = 0; k < 16; k++) send_request(stq_pkg::MODE_START, 4'(k), 32'd1);
        send_request(stq_pkg::MODE_TICK, 4'd0, 32'd0);

        // long hold-off on the result side while requests keep coming
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 40; k++)
                    send_request(stq_pkg::MODE_QUERY, 4'($urandom_range(0, 15)), 32'd0);
            end
        join
        drain_wait();

        // random part: mostly short delays on a small slot window so ticks fire
        for (int n = 0; n < 350; ) begin
            burst = $urandom_range(1, 12);
            id_lo = ($urandom_range(0, 1) != 0) ? 0 : 8;
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: m = stq_pkg::MODE_TICK;
                    3, 4:    m = stq_pkg::MODE_START;
                    5:       m = stq_pkg::MODE_STOP;
                    6:       m = stq_pkg::MODE_CONTINUE;
                    7, 8:    m = stq_pkg::MODE_QUERY;
                    default: m = 3'($urandom_range(5, 7));
                endcase
                d = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
                send_request(m, 4'(id_lo + $urandom_range(0, 7)), d);
                n++;
            end
            if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 30));
            if (n > 200 && n < 215) drain_wait();
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_sorted_timer_queue: done, clean");
        else
            $display("tb_sorted_timer_queue: done, errors");
        $finish;
    end

endmodule
